// ===== hw/rtl/tour_permutation_mutator_top_defines.svh =====
// assertion macros used by the checker
`ifndef TOUR_PERMUTATION_MUTATOR_TOP_DEFINES_SVH
`define TOUR_PERMUTATION_MUTATOR_TOP_DEFINES_SVH

// property must hold at every clock edge outside reset
`define TPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define TPM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/tpm_pkg.sv =====
package tpm_pkg;
	localparam int CITY_W         = 7;
	localparam int POS_W          = 6;
	localparam int OP_W           = 3;
	localparam int ST_W           = 2;
	localparam int DEF_MAX_CITIES = 64;
	localparam int NUM_CITIES_RST = 32;

	localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_SWAP   = 3'd2;
	localparam logic [OP_W-1:0] OP_SHIFT  = 3'd3;
	localparam logic [OP_W-1:0] OP_BLOCK  = 3'd4;
	localparam logic [OP_W-1:0] OP_INVERT = 3'd5;
	localparam logic [OP_W-1:0] OP_CHECK  = 3'd6;

	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_REJECT  = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
endpackage

// ===== hw/rtl/tpm_ram.sv =====
module tpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/tour_permutation_mutator_top.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   op, pos_a, pos_b, count, city_value
// out      output     out_valid / out_ready read_value, status
// cfg      input      cfg_wr_en             cfg_wr_data (num_cities)
//
// one item at a time; read waits on the registered tour ram read, swap, block swap and invert read then write each pair
// shift and a passing check copy through the buffer ram and write back rotated; check first marks seen cities in it
// arst_n clears the sequencer and the output slot and sets num_cities to 32; tour is unset
// a finished item waits in the output register while out_ready is low
module tour_permutation_mutator_top
	import tpm_pkg::*;
#(
	parameter int MAX_CITIES = DEF_MAX_CITIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CITY_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [POS_W-1:0]  pos_a,
	input  logic [POS_W-1:0]  pos_b,
	input  logic [POS_W-1:0]  count,
	input  logic [CITY_W-1:0] city_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CITY_W-1:0] read_value,
	output logic [ST_W-1:0]   status
);
	localparam int IW = $clog2(MAX_CITIES);
	localparam int NW = $clog2(MAX_CITIES + 1);
	localparam int WW = ((NW > CITY_W) ? NW : CITY_W) + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_RDW   = 4'd2;
	localparam logic [3:0] S_SW_RA = 4'd3;
	localparam logic [3:0] S_SW_RB = 4'd4;
	localparam logic [3:0] S_SW_WA = 4'd5;
	localparam logic [3:0] S_SW_WB = 4'd6;
	localparam logic [3:0] S_CP_R  = 4'd7;
	localparam logic [3:0] S_CP_W  = 4'd8;
	localparam logic [3:0] S_WR_R  = 4'd9;
	localparam logic [3:0] S_WR_W  = 4'd10;
	localparam logic [3:0] S_CL    = 4'd11;
	localparam logic [3:0] S_VR    = 4'd12;
	localparam logic [3:0] S_VS    = 4'd13;
	localparam logic [3:0] S_VM    = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	logic [3:0]        state_q, state_d;
	logic [CITY_W-1:0] cfg_q;
	logic              out_valid_q, out_valid_d;
	logic [CITY_W-1:0] out_rv_q;
	logic [ST_W-1:0]   out_st_q;
	logic              out_load;

	logic [OP_W-1:0]   op_q, op_d;
	logic [WW-1:0]     pa_q, pa_d, pb_q, pb_d, cnt_q, cnt_d, n_q, n_d;
	logic [CITY_W-1:0] cv_q, cv_d, tmp_q, tmp_d, res_rv_q, res_rv_d;
	logic [ST_W-1:0]   res_st_q, res_st_d;
	logic [WW-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
	logic [WW-1:0]     base_q, base_d, len_q, len_d, off_q, off_d, start_q, start_d;

	logic              tr_we, tb_we;
	logic [IW-1:0]     tr_waddr, tr_raddr, tb_waddr, tb_raddr;
	logic [CITY_W-1:0] tr_wdata, tr_rdata, tb_wdata, tb_rdata;

	logic [WW-1:0] lo, hi, nm1, cfg_ext, inv_lo, inv_hi, v_ext;
	logic          pa_in, pb_in;

	tpm_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.raddr(tr_raddr), .rdata(tr_rdata)
	);

	tpm_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_buf (
		.clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
		.raddr(tb_raddr), .rdata(tb_rdata)
	);

	assign lo      = (pa_q < pb_q) ? pa_q : pb_q;
	assign hi      = (pa_q < pb_q) ? pb_q : pa_q;
	assign nm1     = n_q - WW'(1);
	assign pa_in   = (pa_q != '0) && (pa_q < n_q);
	assign pb_in   = (pb_q != '0) && (pb_q < n_q);
	assign cfg_ext = WW'(cfg_q);
	assign inv_lo  = (lo == '0) ? WW'(1) : lo;
	assign inv_hi  = (hi > nm1) ? nm1 : hi;
	assign v_ext   = WW'(tr_rdata);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign read_value = out_rv_q;
	assign status     = out_st_q;

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		pa_d     = pa_q;
		pb_d     = pb_q;
		cnt_d    = cnt_q;
		cv_d     = cv_q;
		n_d      = n_q;
		tmp_d    = tmp_q;
		res_rv_d = res_rv_q;
		res_st_d = res_st_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		base_d   = base_q;
		len_d    = len_q;
		off_d    = off_q;
		start_d  = start_q;
		tr_we    = 1'b0;
		tr_waddr = IW'(i_q);
		tr_wdata = tr_rdata;
		tr_raddr = IW'(i_q);
		tb_we    = 1'b0;
		tb_waddr = IW'(k_q);
		tb_wdata = tr_rdata;
		tb_raddr = IW'(j_q);
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d  = op;
					pa_d  = WW'(pos_a);
					pb_d  = WW'(pos_b);
					cnt_d = WW'(count);
					cv_d  = city_value;
					if (cfg_ext < WW'(2)) begin
						n_d = WW'(2);
					end else if (cfg_ext > WW'(MAX_CITIES)) begin
						n_d = WW'(MAX_CITIES);
					end else begin
						n_d = cfg_ext;
					end
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				res_rv_d = '0;
				res_st_d = ST_DONE;
				state_d  = S_FIN;
				case (op_q)
					OP_LOAD: begin
						if (pa_q < n_q) begin
							tr_we    = 1'b1;
							tr_waddr = IW'(pa_q);
							tr_wdata = cv_q;
						end else begin
							res_st_d = ST_REJECT;
						end
					end
					OP_READ: begin
						if (pa_q < n_q) begin
							tr_raddr = IW'(pa_q);
							state_d  = S_RDW;
						end else begin
							res_st_d = ST_REJECT;
						end
					end
					OP_SWAP: begin
						if (pa_in && pb_in) begin
							i_d     = pa_q;
							j_d     = pb_q;
							state_d = S_SW_RA;
						end else begin
							res_st_d = ST_REJECT;
						end
					end
					OP_SHIFT: begin
						if (!pa_in || !pb_in || (hi + cnt_q >= n_q)) begin
							res_st_d = ST_REJECT;
						end else if (cnt_q != '0) begin
							base_d  = lo;
							off_d   = hi + WW'(1) - lo;
							len_d   = hi + WW'(1) - lo + cnt_q;
							k_d     = '0;
							state_d = S_CP_R;
						end
					end
					OP_BLOCK: begin
						if ((cnt_q > (nm1 >> 1)) || !pa_in || !pb_in ||
							(hi + cnt_q > n_q) || (hi - lo < cnt_q)) begin
							res_st_d = ST_REJECT;
						end else if (cnt_q != '0) begin
							i_d     = lo;
							j_d     = hi;
							k_d     = cnt_q;
							state_d = S_SW_RA;
						end
					end
					OP_INVERT: begin
						if (inv_lo < inv_hi) begin
							i_d     = inv_lo;
							j_d     = inv_hi;
							state_d = S_SW_RA;
						end
					end
					OP_CHECK: begin
						k_d     = '0;
						state_d = S_CL;
					end
					default: begin
						res_st_d = ST_REJECT;
					end
				endcase
			end
			S_RDW: begin
				res_rv_d = tr_rdata;
				state_d  = S_FIN;
			end
			S_SW_RA: begin
				tr_raddr = IW'(i_q);
				state_d  = S_SW_RB;
			end
			S_SW_RB: begin
				tr_raddr = IW'(j_q);
				tmp_d    = tr_rdata;
				state_d  = S_SW_WA;
			end
			S_SW_WA: begin
				tr_we    = 1'b1;
				tr_waddr = IW'(i_q);
				tr_wdata = tr_rdata;
				state_d  = S_SW_WB;
			end
			S_SW_WB: begin
				tr_we    = 1'b1;
				tr_waddr = IW'(j_q);
				tr_wdata = tmp_q;
				state_d  = S_FIN;
				case (op_q)
					OP_BLOCK: begin
						i_d = i_q + WW'(1);
						j_d = j_q + WW'(1);
						k_d = k_q - WW'(1);
						if (k_q != WW'(1)) begin
							state_d = S_SW_RA;
						end
					end
					OP_INVERT: begin
						i_d = i_q + WW'(1);
						j_d = j_q - WW'(1);
						if (i_q + WW'(1) < j_q - WW'(1)) begin
							state_d = S_SW_RA;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			// copy segment into the buffer
			S_CP_R: begin
				tr_raddr = IW'(base_q + k_q);
				state_d  = S_CP_W;
			end
			S_CP_W: begin
				tb_we    = 1'b1;
				tb_waddr = IW'(k_q);
				tb_wdata = tr_rdata;
				if (k_q + WW'(1) == len_q) begin
					k_d     = '0;
					j_d     = off_q;
					state_d = S_WR_R;
				end else begin
					k_d     = k_q + WW'(1);
					state_d = S_CP_R;
				end
			end
			// write back rotated by off
			S_WR_R: begin
				tb_raddr = IW'(j_q);
				state_d  = S_WR_W;
			end
			S_WR_W: begin
				tr_we    = 1'b1;
				tr_waddr = IW'(base_q + k_q);
				tr_wdata = tb_rdata;
				if (k_q + WW'(1) == len_q) begin
					state_d = S_FIN;
				end else begin
					k_d     = k_q + WW'(1);
					j_d     = (j_q + WW'(1) == len_q) ? '0 : j_q + WW'(1);
					state_d = S_WR_R;
				end
			end
			// clear seen flags
			S_CL: begin
				tb_we    = 1'b1;
				tb_waddr = IW'(k_q);
				tb_wdata = '0;
				if (k_q + WW'(1) == n_q) begin
					k_d     = '0;
					state_d = S_VR;
				end else begin
					k_d = k_q + WW'(1);
				end
			end
			S_VR: begin
				tr_raddr = IW'(k_q);
				state_d  = S_VS;
			end
			S_VS: begin
				if ((tr_rdata == '0) || (v_ext > n_q)) begin
					res_st_d = ST_INVALID;
					state_d  = S_FIN;
				end else begin
					tb_raddr = IW'(v_ext - WW'(1));
					tmp_d    = tr_rdata;
					if (tr_rdata == CITY_W'(1)) begin
						start_d = k_q;
					end
					state_d = S_VM;
				end
			end
			S_VM: begin
				if (tb_rdata != '0) begin
					res_st_d = ST_INVALID;
					state_d  = S_FIN;
				end else begin
					tb_we    = 1'b1;
					tb_waddr = IW'(WW'(tmp_q) - WW'(1));
					tb_wdata = CITY_W'(1);
					if (k_q + WW'(1) == n_q) begin
						base_d  = '0;
						len_d   = n_q;
						off_d   = start_q;
						k_d     = '0;
						state_d = S_CP_R;
					end else begin
						k_d     = k_q + WW'(1);
						state_d = S_VR;
					end
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cfg_q       <= CITY_W'(NUM_CITIES_RST);
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		pa_q     <= pa_d;
		pb_q     <= pb_d;
		cnt_q    <= cnt_d;
		cv_q     <= cv_d;
		n_q      <= n_d;
		tmp_q    <= tmp_d;
		res_rv_q <= res_rv_d;
		res_st_q <= res_st_d;
		i_q      <= i_d;
		j_q      <= j_d;
		k_q      <= k_d;
		base_q   <= base_d;
		len_q    <= len_d;
		off_q    <= off_d;
		start_q  <= start_d;
		if (out_load) begin
			out_rv_q <= res_rv_q;
			out_st_q <= res_st_q;
		end
	end
endmodule

// ===== hw/rtl/tpm_checker.sv =====
`include "tour_permutation_mutator_top_defines.svh"

module tpm_checker
	import tpm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_wr_en,
	input logic [CITY_W-1:0] cfg_wr_data,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   op,
	input logic [POS_W-1:0]  pos_a,
	input logic [POS_W-1:0]  pos_b,
	input logic [POS_W-1:0]  count,
	input logic [CITY_W-1:0] city_value,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CITY_W-1:0] read_value,
	input logic [ST_W-1:0]   status
);
	`TPM_ASSERT(a_status_code, out_valid |-> (status == ST_DONE || status == ST_REJECT || status == ST_INVALID), "bad status code")
	`TPM_NEVER(a_value_zero, out_valid && (status != ST_DONE) && (read_value != '0), "value on failed item")
	`TPM_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready right after accept")
	`TPM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(read_value) && $stable(status)), "result dropped while stalled")
endmodule

bind tour_permutation_mutator_top tpm_checker u_tpm_checker (.*);
